FILE: hw/rtl/sine_cosine_taylor_macros.svh
// Assertion macros for the sine and cosine block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SINE_COSINE_TAYLOR_MACROS_SVH
`define SINE_COSINE_TAYLOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SCT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sct_pkg.sv
// Shared types, constants and helper functions for the sine and cosine block.
// Depends on nothing; the arithmetic modules, the top level and the testbench import it.
package sct_pkg;

  // Fraction bits of the internal Q5.58 format.
  localparam int QF = 58;

  // Number of Horner steps, one series cell per step.
  localparam int SERIES_TERMS = 8;

  // Pipeline depths of the arithmetic units.
  localparam int QMUL_LAT  = 4;
  localparam int CDIV_LAT  = 3;
  localparam int CELL_LAT  = QMUL_LAT + CDIV_LAT + 1;
  localparam int ROUND_LAT = 2;

  // One in Q5.58, 1/(2*pi) as Q0.64 and 2*pi as Q5.58.
  localparam logic signed [63:0] ONE_Q          = 64'sh0400_0000_0000_0000;
  localparam logic        [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic signed [63:0] TWO_PI_Q58     = 64'sh1921_FB54_442D_1847;

  // A value held as sign and magnitude, as the multipliers produce it.
  typedef struct packed {
    logic        neg;
    logic [62:0] mag;
  } smag_t;

  // Everything one series cell hands to the next.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] x2;
    logic signed [63:0] sacc;
    logic signed [63:0] cacc;
  } cell_bus_t;

  // Sign and magnitude back to two's complement.
  function automatic logic signed [63:0] smag_to_signed(input smag_t v);
    logic [63:0] m;
    m = {1'b0, v.mag};
    return v.neg ? $signed(64'd0 - m) : $signed(m);
  endfunction

  // Two's complement to sign and magnitude; the magnitude is below 2^63 here.
  function automatic smag_t signed_to_smag(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    return '{neg: v[63], mag: m[62:0]};
  endfunction

endpackage

FILE: hw/rtl/sct_angle_if.sv
// Input channel carrying one angle beat with a valid and ready handshake.
// Depends on nothing.
interface sct_angle_if #(
  parameter int ANGLE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

FILE: hw/rtl/sct_result_if.sv
// Result channel carrying one sine and cosine beat with a valid and ready handshake.
// Depends on nothing.
interface sct_result_if #(
  parameter int RESULT_WIDTH = 32
) ();
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] sine_value;
  logic signed [RESULT_WIDTH-1:0] cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink (input valid, input sine_value, input cosine_value, output ready);
endinterface

FILE: hw/rtl/sct_qmul.sv
// Pipelined Q5.58 multiplier, rounding half away from zero, result as sign and magnitude.
// Depends on sct_pkg.
module sct_qmul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output sct_pkg::smag_t     prod_o
);
  import sct_pkg::*;

  localparam logic [64:0] HALF_LSB = 65'd1 << (QF - 1);

  logic [63:0]  mag_a_nxt, mag_b_nxt;
  logic [63:0]  mag_a_r, mag_b_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [64:0]  mid_r, lo_r;
  logic [63:0]  hh2_r;
  logic [62:0]  mag_r;
  logic [127:0] full_w;
  logic         neg_r [QMUL_LAT];

  // Magnitudes of both operands.
  assign mag_a_nxt = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign mag_b_nxt = b_i[63] ? (~b_i + 64'd1) : b_i;

  // Full product with the rounding half added at bit QF-1.
  assign full_w = {hh2_r, 64'd0} + {31'd0, mid_r, 32'd0} + {63'd0, lo_r};

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: magnitudes.
      mag_a_r <= mag_a_nxt;
      mag_b_r <= mag_b_nxt;
      // Stage two: four 32 by 32 partial products.
      ll_r <= mag_a_r[31:0] * mag_b_r[31:0];
      lh_r <= mag_a_r[31:0] * mag_b_r[63:32];
      hl_r <= mag_a_r[63:32] * mag_b_r[31:0];
      hh_r <= mag_a_r[63:32] * mag_b_r[63:32];
      // Stage three: fold the cross terms and add the rounding constant.
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      lo_r  <= {1'b0, ll_r} + HALF_LSB;
      hh2_r <= hh_r;
      // Stage four: final sum, keep 63 bits above the fraction.
      mag_r <= full_w[QF+62:QF];
      // Sign travels alongside.
      neg_r[0] <= a_i[63] ^ b_i[63];
      for (int i = 1; i < QMUL_LAT; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  assign prod_o = '{neg: neg_r[QMUL_LAT-1], mag: mag_r};

endmodule

FILE: hw/rtl/sct_cdiv.sv
// Pipelined division of a magnitude by a fixed divisor, truncating, via an exact reciprocal.
// Depends on sct_pkg.
module sct_cdiv #(
  parameter int DIVISOR = 6
) (
  input  logic           clk,
  input  logic           en,
  input  sct_pkg::smag_t num_i,
  output sct_pkg::smag_t quo_o
);
  import sct_pkg::*;

  // Reciprocal rounded up, wide enough to be exact for any 63-bit numerator.
  localparam int           SHIFT      = 63 + $clog2(DIVISOR);
  localparam logic [127:0] RECIP_WIDE = ((128'd1 << SHIFT) + 128'(DIVISOR - 1))
                                        / 128'(DIVISOR);
  localparam logic [63:0]  RECIP      = RECIP_WIDE[63:0];
  localparam logic [31:0]  RECIP_LO   = RECIP[31:0];
  localparam logic [31:0]  RECIP_HI   = RECIP[63:32];

  logic [31:0]  num_lo, num_hi;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [64:0]  mid_r;
  logic [63:0]  lo2_r, hh2_r;
  logic [127:0] full_w, shifted_w;
  logic [62:0]  quo_r;
  logic         neg_r [CDIV_LAT];

  assign num_lo = num_i.mag[31:0];
  assign num_hi = {1'b0, num_i.mag[62:32]};

  assign full_w    = {hh2_r, 64'd0} + {31'd0, mid_r, 32'd0} + {64'd0, lo2_r};
  assign shifted_w = full_w >> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: partial products against the constant.
      ll_r <= num_lo * RECIP_LO;
      lh_r <= num_lo * RECIP_HI;
      hl_r <= num_hi * RECIP_LO;
      hh_r <= num_hi * RECIP_HI;
      // Stage two: fold the cross terms.
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      lo2_r <= ll_r;
      hh2_r <= hh_r;
      // Stage three: final sum and shift gives the quotient.
      quo_r <= shifted_w[62:0];
      neg_r[0] <= num_i.neg;
      for (int i = 1; i < CDIV_LAT; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  assign quo_o = '{neg: neg_r[CDIV_LAT-1], mag: quo_r};

endmodule

FILE: hw/rtl/sct_cell.sv
// One Horner step of both series: acc = 1 - x^2*acc/d for the sine and the cosine.
// Depends on sct_pkg, sct_qmul and sct_cdiv.
module sct_cell #(
  parameter int TERM = 8
) (
  input  logic               clk,
  input  logic               en,
  input  sct_pkg::cell_bus_t bus_i,
  output sct_pkg::cell_bus_t bus_o
);
  import sct_pkg::*;

  localparam int SIN_DIV = (2 * TERM) * (2 * TERM + 1);
  localparam int COS_DIV = (2 * TERM - 1) * (2 * TERM);
  localparam int HOLD    = QMUL_LAT + CDIV_LAT;

  smag_t              sin_prod, cos_prod, sin_quo, cos_quo;
  logic signed [63:0] sacc_nxt, cacc_nxt;
  logic signed [63:0] x_dly_r  [HOLD];
  logic signed [63:0] x2_dly_r [HOLD];
  cell_bus_t          bus_r;

  // Sine lane.
  sct_qmul u_sin_mul (.clk(clk), .en(en), .a_i(bus_i.x2), .b_i(bus_i.sacc), .prod_o(sin_prod));
  sct_cdiv #(.DIVISOR(SIN_DIV)) u_sin_div (
    .clk(clk), .en(en), .num_i(sin_prod), .quo_o(sin_quo)
  );

  // Cosine lane.
  sct_qmul u_cos_mul (.clk(clk), .en(en), .a_i(bus_i.x2), .b_i(bus_i.cacc), .prod_o(cos_prod));
  sct_cdiv #(.DIVISOR(COS_DIV)) u_cos_div (
    .clk(clk), .en(en), .num_i(cos_prod), .quo_o(cos_quo)
  );

  // Subtract the scaled term from one.
  assign sacc_nxt = ONE_Q - smag_to_signed(sin_quo);
  assign cacc_nxt = ONE_Q - smag_to_signed(cos_quo);

  always_ff @(posedge clk) begin
    if (en) begin
      // x and x^2 ride along with the lanes.
      x_dly_r[0]  <= bus_i.x;
      x2_dly_r[0] <= bus_i.x2;
      for (int i = 1; i < HOLD; i++) begin
        x_dly_r[i]  <= x_dly_r[i-1];
        x2_dly_r[i] <= x2_dly_r[i-1];
      end
      bus_r.x    <= x_dly_r[HOLD-1];
      bus_r.x2   <= x2_dly_r[HOLD-1];
      bus_r.sacc <= sacc_nxt;
      bus_r.cacc <= cacc_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

FILE: hw/rtl/sct_round.sv
// Rounds a Q5.58 sign and magnitude value to signed Q2 output format with saturation.
// Depends on sct_pkg.
module sct_round #(
  parameter int RESULT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           en,
  input  sct_pkg::smag_t                 val_i,
  output logic signed [RESULT_WIDTH-1:0] res_o
);
  import sct_pkg::*;

  localparam int          SH      = QF - (RESULT_WIDTH - 2);
  localparam logic [63:0] HALF    = 64'd1 << (SH - 1);
  localparam logic [63:0] LIM_POS = (64'd1 << (RESULT_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] LIM_NEG = 64'd1 << (RESULT_WIDTH - 1);

  logic [63:0]             rnd_nxt, rnd_r, clamp_w, negated_w;
  logic                    neg_r;
  logic [RESULT_WIDTH-1:0] res_nxt;
  logic [RESULT_WIDTH-1:0] res_r;

  // Round half away from zero on the magnitude.
  assign rnd_nxt = ({1'b0, val_i.mag} + HALF) >> SH;

  // Clamp to the range of the sign, then apply it.
  always_comb begin
    if (neg_r) begin
      clamp_w = (rnd_r > LIM_NEG) ? LIM_NEG : rnd_r;
    end else begin
      clamp_w = (rnd_r > LIM_POS) ? LIM_POS : rnd_r;
    end
    negated_w = 64'd0 - clamp_w;
    res_nxt   = neg_r ? negated_w[RESULT_WIDTH-1:0] : clamp_w[RESULT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r <= rnd_nxt;
      neg_r <= val_i.neg;
      res_r <= res_nxt;
    end
  end

  assign res_o = $signed(res_r);

endmodule

FILE: hw/rtl/sine_cosine_taylor.sv
// sine_cosine_taylor: top level; uses sct_pkg, both channel interfaces, sct_cell,
// sct_qmul and sct_round. One input beat is taken every cycle while the skid stage
// is empty. Most of the depth comes from the eight series cells, each a split
// multiplier, a reciprocal divider and a subtract stage.
// Synchronous active-low reset clears the valid chain and the output and skid flags.
`include "sine_cosine_taylor_macros.svh"

module sine_cosine_taylor #(
  parameter int ANGLE_WIDTH  = 32,
  parameter int RESULT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sct_angle_if.sink    in_chan,
  sct_result_if.source out_chan
);
  import sct_pkg::*;

  localparam int          FRAC       = ANGLE_WIDTH - 8;
  localparam logic [63:0] TURN_SCALE = (INV_TWO_PI_Q64 + (64'd1 << (FRAC - 1))) >> FRAC;
  localparam logic [31:0] SCALE_LO   = TURN_SCALE[31:0];
  localparam logic [31:0] SCALE_HI   = TURN_SCALE[63:32];
  localparam int          FRONT_LAT  = 2 + QMUL_LAT + 1 + QMUL_LAT + 1;
  localparam int          PIPE_LAT   = FRONT_LAT + SERIES_TERMS * CELL_LAT
                                       + QMUL_LAT + ROUND_LAT;

  // Pipeline advance and valid chain.
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  // Angle reduction.
  logic [63:0]        angle_ext;
  logic [63:0]        pp_ll_nxt;
  logic [31:0]        pp_lh_nxt, pp_hl_nxt;
  logic [63:0]        pp_ll_r;
  logic [31:0]        pp_lh_r, pp_hl_r;
  logic [31:0]        cross_sum;
  logic [63:0]        turn_prod;
  logic signed [63:0] turns_nxt, turns_r;

  // x, x^2 and the head of the cell chain.
  smag_t              x_sm, sq_sm;
  logic signed [63:0] x_r;
  logic signed [63:0] x_dly_r [QMUL_LAT];
  cell_bus_t          head_r;
  cell_bus_t          chain [SERIES_TERMS+1];

  // Final multiply and rounding.
  smag_t                          sin_sm, cos_sm_r;
  logic signed [63:0]             cacc_dly_r [QMUL_LAT-1];
  logic signed [RESULT_WIDTH-1:0] sine_res, cosine_res;

  // Output register and skid stage.
  logic                           out_valid_r, out_valid_nxt;
  logic                           skid_valid_r, skid_valid_nxt;
  logic                           out_load, skid_load, out_from_skid;
  logic                           out_take, pipe_done;
  logic signed [RESULT_WIDTH-1:0] out_sin_r, out_cos_r, skid_sin_r, skid_cos_r;

  // Turns: angle times 1/(2*pi), modulo 2^64, built from 32-bit partial products.
  assign angle_ext = {{(64 - ANGLE_WIDTH){in_chan.angle[ANGLE_WIDTH-1]}}, in_chan.angle};
  assign pp_ll_nxt = angle_ext[31:0] * SCALE_LO;
  assign pp_lh_nxt = angle_ext[31:0] * SCALE_HI;
  assign pp_hl_nxt = angle_ext[63:32] * SCALE_LO;

  // The top 58 bits, sign-extended, give the turns as signed Q5.58 in [-1/2, 1/2).
  assign cross_sum = pp_lh_r + pp_hl_r;
  assign turn_prod = pp_ll_r + {cross_sum, 32'd0};
  assign turns_nxt = $signed({{6{turn_prod[63]}}, turn_prod[63:6]});

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      turns_r <= turns_nxt;
    end
  end

  // x = turns * 2*pi.
  sct_qmul u_qmul_x (.clk(clk), .en(en), .a_i(turns_r), .b_i(TWO_PI_Q58), .prod_o(x_sm));

  // x^2, with x held back to meet it.
  sct_qmul u_qmul_sq (.clk(clk), .en(en), .a_i(x_r), .b_i(x_r), .prod_o(sq_sm));

  always_ff @(posedge clk) begin
    if (en) begin
      x_r        <= smag_to_signed(x_sm);
      x_dly_r[0] <= x_r;
      for (int i = 1; i < QMUL_LAT; i++) begin
        x_dly_r[i] <= x_dly_r[i-1];
      end
      head_r.x    <= x_dly_r[QMUL_LAT-1];
      head_r.x2   <= smag_to_signed(sq_sm);
      head_r.sacc <= ONE_Q;
      head_r.cacc <= ONE_Q;
    end
  end

  // Row of series cells, highest term first.
  assign chain[0] = head_r;

  for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_cells
    sct_cell #(.TERM(SERIES_TERMS - g)) u_cell (
      .clk  (clk),
      .en   (en),
      .bus_i(chain[g]),
      .bus_o(chain[g+1])
    );
  end

  // Sine = x * acc; the cosine accumulator waits for it.
  sct_qmul u_qmul_sin (
    .clk(clk), .en(en), .a_i(chain[SERIES_TERMS].x), .b_i(chain[SERIES_TERMS].sacc),
    .prod_o(sin_sm)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cacc_dly_r[0] <= chain[SERIES_TERMS].cacc;
      for (int i = 1; i < QMUL_LAT - 1; i++) begin
        cacc_dly_r[i] <= cacc_dly_r[i-1];
      end
      cos_sm_r <= signed_to_smag(cacc_dly_r[QMUL_LAT-2]);
    end
  end

  sct_round #(.RESULT_WIDTH(RESULT_WIDTH)) u_round_sin (
    .clk(clk), .en(en), .val_i(sin_sm), .res_o(sine_res)
  );

  sct_round #(.RESULT_WIDTH(RESULT_WIDTH)) u_round_cos (
    .clk(clk), .en(en), .val_i(cos_sm_r), .res_o(cosine_res)
  );

  // The whole pipeline advances while the skid stage is empty.
  assign en            = !skid_valid_r;
  assign in_chan.ready = en;
  assign out_take      = out_valid_r && out_chan.ready;
  assign pipe_done     = vld_r[PIPE_LAT-1] && en;

  // Output register with a skid stage behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    skid_load      = 1'b0;
    out_from_skid  = 1'b0;
    if (skid_valid_r) begin
      if (out_take) begin
        out_load       = 1'b1;
        out_from_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (pipe_done) begin
      if (!out_valid_r || out_take) begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        skid_load      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (en) begin
        vld_r <= {vld_r[PIPE_LAT-2:0], in_chan.valid};
      end
    end
  end

  // Result data.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sin_r <= out_from_skid ? skid_sin_r : sine_res;
      out_cos_r <= out_from_skid ? skid_cos_r : cosine_res;
    end
    if (skid_load) begin
      skid_sin_r <= sine_res;
      skid_cos_r <= cosine_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sine_value   = out_sin_r;
  assign out_chan.cosine_value = out_cos_r;

  // A held beat in the skid stage always has one in front of it.
  `SCT_ASSERT_IMPLY(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  // A stalled pipeline keeps its valid chain.
  `SCT_ASSERT_NEXT(a_stall_holds_chain, !en, $stable(vld_r), "valid chain moved while stalled")
  // A finished beat meeting a blocked output lands in the skid stage.
  `SCT_ASSERT_NEXT(a_blocked_beat_skids,
    pipe_done && out_valid_r && !out_chan.ready, skid_valid_r, "finished beat was dropped")
  // An accepted beat enters the valid chain.
  `SCT_ASSERT_NEXT(a_accept_enters_chain,
    in_chan.valid && en, vld_r[0], "accepted beat missing from pipeline")

endmodule

FILE: verif/sine_cosine_taylor_test.sv
// Self-checking testbench for sine_cosine_taylor: angle beats in, sine and cosine beats out.
// Depends on sct_pkg, sct_angle_if, sct_result_if and the sine_cosine_taylor RTL.
// A table of directed angles is followed by random angles, checked against typed-in or predicted results.
module sine_cosine_taylor_test;
  import sct_pkg::*;

  localparam int ANGLE_W    = 32;
  localparam int RESULT_W   = 32;
  localparam int ANGLE_FRAC = ANGLE_W - 8;
  localparam int RES_SHIFT  = QF - (RESULT_W - 2);
  localparam int RANDOM_ANGLES = 600;
  localparam int CYCLE_LIMIT   = 50000;
  localparam int TAIL_CYCLES   = 100;
  localparam int REPORT_LIMIT  = 10;

  // Q8.24 approximations of a quarter turn and a full turn.
  localparam int QUARTER_TURN = 26353589;
  localparam int FULL_TURN    = 105414357;

  typedef struct packed {
    logic signed [RESULT_W-1:0] sine;
    logic signed [RESULT_W-1:0] cosine;
  } sincos_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      known;
    sincos_t                   want;
  } angle_row_t;

  // Directed angles. Only zero has its result typed in; the rest go to the predictor.
  localparam int DIRECTED_ROWS = 21;
  localparam angle_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'sh0000_0000, 1'b1, '{32'sh0000_0000, 32'sh4000_0000}},
    '{32'sh0000_0001, 1'b0, '{32'sh0, 32'sh0}},
    '{-32'sd1,        1'b0, '{32'sh0, 32'sh0}},
    '{32'sh7FFF_FFFF, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sh8000_0000, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sd26353589,  1'b0, '{32'sh0, 32'sh0}},
    '{-32'sd26353589, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sd52707179,  1'b0, '{32'sh0, 32'sh0}},
    '{32'sd52707178,  1'b0, '{32'sh0, 32'sh0}},
    '{-32'sd52707179, 1'b0, '{32'sh0, 32'sh0}},
    '{-32'sd52707178, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sd105414357, 1'b0, '{32'sh0, 32'sh0}},
    '{-32'sd105414357, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sh0100_0000, 1'b0, '{32'sh0, 32'sh0}},
    '{32'shFF00_0000, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sh5555_5555, 1'b0, '{32'sh0, 32'sh0}},
    '{32'shAAAA_AAAA, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sh00FF_FFFF, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sh4000_0000, 1'b0, '{32'sh0, 32'sh0}},
    '{32'shC000_0000, 1'b0, '{32'sh0, 32'sh0}},
    '{32'sh0000_FFFF, 1'b0, '{32'sh0, 32'sh0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sct_angle_if #(.ANGLE_WIDTH(ANGLE_W)) angle_chan ();
  sct_result_if #(.RESULT_WIDTH(RESULT_W)) result_chan ();

  sine_cosine_taylor #(
    .ANGLE_WIDTH(ANGLE_W),
    .RESULT_WIDTH(RESULT_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(angle_chan),
    .out_chan(result_chan)
  );

  angle_row_t angle_feed [$];
  sincos_t    sincos_due [$];
  angle_row_t offered;
  int         feed_total = 0;
  int         angles_taken = 0;
  int         results_taken = 0;
  int         mismatch_count = 0;
  int         hold_left = 0;
  int         cycle_count = 0;
  bit         sender_gap;
  bit         ready_next;

  initial begin
    forever #1 clk = ~clk;
  end

  // Product of two signed Q5.58 values, rounded half away from zero.
  function automatic logic signed [63:0] q58_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    logic [63:0]  mag;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod + (128'd1 << (QF - 1));
    mag = {1'b0, prod[QF+62:QF]};
    return (a[63] != b[63]) ? $signed(64'd0 - mag) : $signed(mag);
  endfunction

  // Q5.58 down to the Q2.30 result, rounded half away from zero and saturated.
  function automatic logic signed [RESULT_W-1:0] q58_to_result(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'd0 - v : v;
    r = (m + (64'd1 << (RES_SHIFT - 1))) >> RES_SHIFT;
    if (v[63]) begin
      if (r > (64'd1 << (RESULT_W - 1)))
        r = 64'd1 << (RESULT_W - 1);
      r = 64'd0 - r;
    end else if (r > ((64'd1 << (RESULT_W - 1)) - 1)) begin
      r = (64'd1 << (RESULT_W - 1)) - 1;
    end
    return r[RESULT_W-1:0];
  endfunction

  // Reduces the angle to [-pi, pi) and runs both Horner series.
  function automatic sincos_t sincos_of(input logic signed [ANGLE_W-1:0] angle);
    logic [63:0]        scale;
    logic [63:0]        turns_u;
    logic signed [63:0] turns;
    logic signed [63:0] x;
    logic signed [63:0] x2;
    logic signed [63:0] sacc;
    logic signed [63:0] cacc;
    logic signed [63:0] ds;
    logic signed [63:0] dc;
    sincos_t            res;
    scale = (INV_TWO_PI_Q64 + (64'd1 << (ANGLE_FRAC - 1))) >> ANGLE_FRAC;
    turns_u = {{(64 - ANGLE_W){angle[ANGLE_W-1]}}, angle} * scale;
    turns_u = turns_u + (64'd1 << 63);
    turns = $signed((turns_u >> (64 - QF)) - (64'd1 << (QF - 1)));
    x = q58_mul(turns, TWO_PI_Q58);
    x2 = q58_mul(x, x);
    sacc = ONE_Q;
    cacc = ONE_Q;
    for (int k = SERIES_TERMS; k >= 1; k--) begin
      ds = 2 * k * (2 * k + 1);
      dc = (2 * k - 1) * (2 * k);
      sacc = ONE_Q - q58_mul(x2, sacc) / ds;
      cacc = ONE_Q - q58_mul(x2, cacc) / dc;
    end
    res.sine = q58_to_result(q58_mul(x, sacc));
    res.cosine = q58_to_result(cacc);
    return res;
  endfunction

  // Random angles: the full range, a few turns either side of zero, near quarter
  // turns, and tiny angles.
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int quarter;
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(4 * FULL_TURN)) - 2 * FULL_TURN;
      2: begin
        quarter = int'($urandom_range(80)) - 40;
        return quarter * QUARTER_TURN + int'($urandom_range(128)) - 64;
      end
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [RESULT_W-1:0] want,
                                 input logic [RESULT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("beat %0d: %s expected %h, got %h", results_taken, field, want, got);
  endtask

  // Sender: offers the next angle once the previous beat is taken, with random gaps
  // outside a steady window.
  always @(posedge clk) begin
    if (!rst_n) begin
      angle_chan.valid <= 1'b0;
      angle_chan.angle <= '0;
    end else if (!angle_chan.valid || angle_chan.ready) begin
      if (angle_chan.valid) begin
        sincos_due.push_back(offered.known ? offered.want : sincos_of(offered.angle));
        angles_taken++;
      end
      sender_gap = (angles_taken < 250 || angles_taken >= 400) && ($urandom_range(99) < 13);
      if (angle_feed.size() > 0 && !sender_gap) begin
        offered = angle_feed.pop_front();
        angle_chan.valid <= 1'b1;
        angle_chan.angle <= offered.angle;
      end else begin
        angle_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result beat against the oldest prediction. Once, it holds
  // ready low for a long stretch so that the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      result_chan.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (result_chan.valid && result_chan.ready) begin
        if (sincos_due.size() == 0) begin
          report_mismatch("unexpected beat, sine", '0, result_chan.sine_value);
        end else begin
          if (sincos_due[0].sine !== result_chan.sine_value)
            report_mismatch("sine", sincos_due[0].sine, result_chan.sine_value);
          if (sincos_due[0].cosine !== result_chan.cosine_value)
            report_mismatch("cosine", sincos_due[0].cosine, result_chan.cosine_value);
          void'(sincos_due.pop_front());
        end
        results_taken++;
        if (results_taken == 450)
          hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = (results_taken >= 250 && results_taken < 400) ||
                     ($urandom_range(99) >= 13);
      end
      result_chan.ready <= ready_next;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Builds the stimulus, releases reset and waits for every prediction to be met.
  initial begin
    for (int i = 0; i < DIRECTED_ROWS; i++)
      angle_feed.push_back(DIRECTED[i]);
    for (int i = 0; i < RANDOM_ANGLES; i++)
      angle_feed.push_back('{random_angle(), 1'b0, '{'0, '0}});
    feed_total = angle_feed.size();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (angles_taken < feed_total || sincos_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_count += sincos_due.size();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
